// ===== rtl/tlp_pkg.sv =====
// Shared types and constants for the tiled 4bpp line plotter.
`timescale 1ns / 1ps
package tlp_pkg;

  // Operation carried by one input beat.
  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  localparam int CoordW    = 10;  // end point coordinate width
  localparam int DeltaW    = 11;  // end point difference width
  localparam int IndexW    = 14;  // read word index width
  localparam int DataW     = 16;  // store word width
  localparam int DotsW     = 12;  // dot count width
  localparam int StepW     = 10;  // line step counter width
  localparam int ColorW    = 4;   // palette index width
  localparam int PixW      = 12;  // signed pixel position width
  localparam int AddrFullW = 17;  // wide word address used before narrowing

  localparam logic [ColorW-1:0] DefaultColor = 4'd1;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    kind_e                    kind;
    logic signed [CoordW-1:0] x_start;
    logic signed [CoordW-1:0] y_start;
    logic [StepW-1:0]         last_step;
    logic [IndexW-1:0]        read_index;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic [DotsW-1:0] dots;
  } result_t;

endpackage

// ===== rtl/tlp_div.sv =====
// Bit-serial divider that forms both DDA increments of a line.
`timescale 1ns / 1ps
module tlp_div #(
  parameter int FRAC_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [tlp_pkg::DeltaW-1:0] dx_i,
  input  logic signed [tlp_pkg::DeltaW-1:0] dy_i,
  input  logic [tlp_pkg::DeltaW-1:0]        n_i,
  output logic                              done_o,
  output logic signed [FRAC_BITS:0]         qx_o,
  output logic signed [FRAC_BITS:0]         qy_o
);

  localparam int DW   = tlp_pkg::DeltaW;
  localparam int CntW = $clog2(FRAC_BITS);
  localparam logic [CntW-1:0] LastCnt = CntW'(FRAC_BITS - 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DW-1:0]   n_q, rx_q, ry_q;
  logic [FRAC_BITS-1:0] qx_q, qy_q;
  logic            negx_q, negy_q;

  logic [DW-1:0] dx_mag, dy_mag;
  logic [DW:0]   tx, ty, diffx, diffy;
  logic          gex, gey;
  logic [DW-1:0] rx_d, ry_d;
  logic signed [FRAC_BITS:0] qx_pos, qy_pos;

  // Magnitudes of the deltas; the quotient sign is restored at the end.
  assign dx_mag = dx_i[DW-1] ? DW'(-dx_i) : DW'(dx_i);
  assign dy_mag = dy_i[DW-1] ? DW'(-dy_i) : DW'(dy_i);

  // One restoring step per cycle: the remainder is doubled and n taken off.
  assign tx    = {rx_q, 1'b0};
  assign ty    = {ry_q, 1'b0};
  assign diffx = tx - {1'b0, n_q};
  assign diffy = ty - {1'b0, n_q};
  assign gex   = tx >= {1'b0, n_q};
  assign gey   = ty >= {1'b0, n_q};
  assign rx_d  = gex ? diffx[DW-1:0] : tx[DW-1:0];
  assign ry_d  = gey ? diffy[DW-1:0] : ty[DW-1:0];

  // Sequencing of the iterations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
    end
  end

  // Remainders and quotient bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= n_i;
      rx_q   <= dx_mag;
      ry_q   <= dy_mag;
      qx_q   <= '0;
      qy_q   <= '0;
      negx_q <= dx_i[DW-1];
      negy_q <= dy_i[DW-1];
    end else if (busy_q) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
      qx_q <= {qx_q[FRAC_BITS-2:0], gex};
      qy_q <= {qy_q[FRAC_BITS-2:0], gey};
    end
  end

  // Truncation toward zero: divide magnitudes, then apply the sign.
  assign qx_pos = {1'b0, qx_q};
  assign qy_pos = {1'b0, qy_q};
  assign qx_o   = negx_q ? -qx_pos : qx_pos;
  assign qy_o   = negy_q ? -qy_pos : qy_pos;
  assign done_o = done_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider finished without running");

endmodule

// ===== rtl/tlp_front.sv =====
// Front end: accepts input beats, classifies them and prepares line commands.
`timescale 1ns / 1ps
module tlp_front #(
  parameter int FRAC_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [1:0]                        kind_i,
  input  logic signed [tlp_pkg::CoordW-1:0] x_start_i,
  input  logic signed [tlp_pkg::CoordW-1:0] y_start_i,
  input  logic signed [tlp_pkg::CoordW-1:0] x_end_i,
  input  logic signed [tlp_pkg::CoordW-1:0] y_end_i,
  input  logic [tlp_pkg::IndexW-1:0]        read_index_i,
  input  logic                              cmd_full_i,
  output logic                              busy_o,
  output logic                              cmd_push_o,
  output tlp_pkg::cmd_t                     cmd_o,
  output logic signed [FRAC_BITS:0]         ax_o,
  output logic signed [FRAC_BITS:0]         ay_o
);

  localparam int DW = tlp_pkg::DeltaW;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } state_e;

  state_e           state_q;
  tlp_pkg::cmd_t    cmd_q;
  tlp_pkg::kind_e   kind;
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]    mx, my, mmax, n;
  logic             div_start, div_done;

  // Line geometry: deltas, the longer axis and the step count.
  assign kind = tlp_pkg::kind_e'(kind_i);
  assign dx   = DW'(x_end_i) - DW'(x_start_i);
  assign dy   = DW'(y_end_i) - DW'(y_start_i);
  assign mx   = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign my   = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign mmax = (mx > my) ? mx : my;
  assign n    = mmax + DW'(1);

  assign div_start = accept_i && (kind == tlp_pkg::KIND_LINE);

  tlp_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .dx_i   (dx),
    .dy_i   (dy),
    .n_i    (n),
    .done_o (div_done),
    .qx_o   (ax_o),
    .qy_o   (ay_o)
  );

  // Command holding register.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cmd_q.kind       <= kind;
      cmd_q.x_start    <= x_start_i;
      cmd_q.y_start    <= y_start_i;
      cmd_q.last_step  <= mmax[tlp_pkg::StepW-1:0];
      cmd_q.read_index <= read_index_i;
    end
  end

  // One beat in flight: wait for the divider on lines, then hand over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (div_start) begin
            state_q <= F_DIV;
          end else if (accept_i) begin
            state_q <= F_PUSH;
          end
        end
        F_DIV: begin
          if (div_done) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!cmd_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign busy_o     = (state_q != F_IDLE);
  assign cmd_push_o = (state_q == F_PUSH) && !cmd_full_i;
  assign cmd_o      = cmd_q;

endmodule

// ===== rtl/tlp_cmd_fifo.sv =====
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
module tlp_cmd_fifo #(
  parameter int WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command queue read while empty");

endmodule

// ===== rtl/tlp_back.sv =====
// Back end: tile store, clearing sweep, line plotting sequencer and result register.
`timescale 1ns / 1ps
module tlp_back #(
  parameter int TILES_WIDE = 32,
  parameter int TILES_HIGH = 24,
  parameter int FRAC_BITS  = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_empty_i,
  output logic                             cmd_pop_o,
  input  tlp_pkg::cmd_t                    cmd_i,
  input  logic signed [FRAC_BITS:0]        ax_i,
  input  logic signed [FRAC_BITS:0]        ay_i,
  input  logic [tlp_pkg::ColorW-1:0]       color_i,
  output logic                             init_busy_o,
  output logic                             res_empty_o,
  input  logic                             res_pop_i,
  output tlp_pkg::result_t                 res_o
);

  localparam int StoreWords = TILES_WIDE * TILES_HIGH * 16;
  localparam int AddrW      = $clog2(StoreWords);
  localparam int ScreenW    = TILES_WIDE * 8;
  localparam int ScreenH    = TILES_HIGH * 8;
  localparam int PixW       = tlp_pkg::PixW;
  localparam int AccW       = FRAC_BITS + PixW;
  localparam int DataW      = tlp_pkg::DataW;
  localparam int DotsW      = tlp_pkg::DotsW;
  localparam int StepW      = tlp_pkg::StepW;
  localparam int FullW      = tlp_pkg::AddrFullW;
  localparam logic [AddrW-1:0]       LastAddr   = AddrW'(StoreWords - 1);
  localparam logic signed [PixW-1:0] ScreenWPix = PixW'(ScreenW);
  localparam logic signed [PixW-1:0] ScreenHPix = PixW'(ScreenH);

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_RD0,
    B_WR0,
    B_WR1,
    B_RDWAIT,
    B_DONE
  } state_e;

  state_e                   state_q;
  logic                     clear_cmd_q;
  logic [AddrW-1:0]         clr_addr_q;
  logic [StepW-1:0]         step_q;
  logic                     out_valid_q;

  logic signed [tlp_pkg::CoordW-1:0] x0_q, y0_q;
  logic [StepW-1:0]         last_q;
  logic signed [FRAC_BITS:0] ax_q, ay_q;
  logic signed [AccW-1:0]   accx_q, accy_q;
  logic [DotsW-1:0]         dots_q;
  logic [DataW-1:0]         data_q;
  logic                     rd_ok_q;
  tlp_pkg::result_t         out_q;

  logic [DataW-1:0]         mem [StoreWords];
  logic [DataW-1:0]         rdata_q;
  logic                     we;
  logic [AddrW-1:0]         waddr, raddr;
  logic [DataW-1:0]         wdata;

  logic signed [PixW-1:0]   px, py, py1;
  logic                     x_on, on0, on1;
  logic [AddrW-1:0]         addr0, addr1;
  logic [DataW-1:0]         mask;
  logic [FullW-1:0]         idx_full;
  logic                     out_free;

  // Word address of an on-screen pixel in the tiled layout.
  function automatic logic [AddrW-1:0] word_addr(logic [8:0] x, logic [8:0] y);
    logic [FullW-1:0] tile;
    logic [FullW-1:0] full;
    tile = FullW'(y[8:3]) * FullW'(TILES_WIDE) + FullW'(x[8:3]);
    full = {tile[FullW-5:0], y[2:0], x[2]};
    return full[AddrW-1:0];
  endfunction

  // Current DDA position: start point plus the floored accumulators.
  assign px  = PixW'(x0_q) + accx_q[AccW-1:FRAC_BITS];
  assign py  = PixW'(y0_q) + accy_q[AccW-1:FRAC_BITS];
  assign py1 = py + PixW'(1);

  assign x_on  = (px >= 0) && (px < ScreenWPix);
  assign on0   = x_on && (py >= 0) && (py < ScreenHPix);
  assign on1   = x_on && (py1 >= 0) && (py1 < ScreenHPix);
  assign addr0 = word_addr(px[8:0], py[8:0]);
  assign addr1 = word_addr(px[8:0], py1[8:0]);
  assign mask  = DataW'(color_i) << {px[1:0], 2'b00};

  assign idx_full = FullW'(cmd_i.read_index);
  assign out_free = !out_valid_q || res_pop_i;

  // Store port control: sweep writes, read-modify-write on dots, word reads.
  always_comb begin
    we    = 1'b0;
    waddr = addr0;
    wdata = rdata_q | mask;
    raddr = addr0;
    unique case (state_q)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr_q;
        wdata = '0;
      end
      B_IDLE: begin
        raddr = idx_full[AddrW-1:0];
      end
      B_WR0: begin
        we    = on0;
        raddr = addr1;
      end
      B_WR1: begin
        we    = on1;
        waddr = addr1;
      end
      default: begin
      end
    endcase
  end

  // Tile store with registered read data.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Sequencer and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clear_cmd_q <= 1'b0;
      clr_addr_q  <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_CLEAR: begin
          if (clr_addr_q == LastAddr) begin
            clr_addr_q  <= '0;
            clear_cmd_q <= 1'b1;
            state_q     <= clear_cmd_q ? B_DONE : B_IDLE;
          end else begin
            clr_addr_q <= clr_addr_q + AddrW'(1);
          end
        end
        B_IDLE: begin
          if (!cmd_empty_i) begin
            unique case (cmd_i.kind)
              tlp_pkg::KIND_CLEAR: begin
                clr_addr_q <= '0;
                state_q    <= B_CLEAR;
              end
              tlp_pkg::KIND_LINE: begin
                step_q  <= '0;
                state_q <= B_RD0;
              end
              tlp_pkg::KIND_READ: state_q <= B_RDWAIT;
              tlp_pkg::KIND_NONE: state_q <= B_DONE;
              default:            state_q <= B_DONE;
            endcase
          end
        end
        B_RD0: state_q <= B_WR0;
        B_WR0: state_q <= B_WR1;
        B_WR1: begin
          if (step_q == last_q) begin
            state_q <= B_DONE;
          end else begin
            step_q  <= step_q + StepW'(1);
            state_q <= B_RD0;
          end
        end
        B_RDWAIT: state_q <= B_DONE;
        B_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // Command fields, accumulators and the result being built.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          x0_q    <= cmd_i.x_start;
          y0_q    <= cmd_i.y_start;
          last_q  <= cmd_i.last_step;
          ax_q    <= ax_i;
          ay_q    <= ay_i;
          accx_q  <= '0;
          accy_q  <= '0;
          dots_q  <= '0;
          data_q  <= '0;
          rd_ok_q <= idx_full < FullW'(StoreWords);
        end
      end
      B_WR0: begin
        dots_q <= dots_q + DotsW'(on0);
      end
      B_WR1: begin
        dots_q <= dots_q + DotsW'(on1);
        accx_q <= accx_q + AccW'(ax_q);
        accy_q <= accy_q + AccW'(ay_q);
      end
      B_RDWAIT: begin
        data_q <= rd_ok_q ? rdata_q : '0;
      end
      B_DONE: begin
        if (out_free) begin
          out_q.read_data <= data_q;
          out_q.dots      <= dots_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd_pop_o   = (state_q == B_IDLE) && !cmd_empty_i;
  assign init_busy_o = (state_q == B_CLEAR) && !clear_cmd_q;
  assign res_empty_o = !out_valid_q;
  assign res_o       = out_q;

  a_init_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_busy_o |=> !init_busy_o)
    else $error("power-on clearing sweep restarted");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_WR1) |-> (step_q <= last_q))
    else $error("line step counter ran past the last step");

endmodule

// ===== rtl/tiled_4bpp_line_plotter_core.sv =====
// Top level of the tiled 4bpp line plotter: ports, color register and wiring.
`timescale 1ns / 1ps
// Usage
// Commands enter through a queue-style port: a beat is taken when push is
// high and full is low. Results leave the same way: the oldest result sits
// on read_data_o and dots_plotted_o while empty is low, and pop takes it.
// Every command returns exactly one result beat. The color register is
// written through cfg_valid_i/cfg_data_i; cfg_ready_o is always high.
// Flow: the front end holds one command; a line first passes through the
// bit-serial divider. The back end then handles each line step as a read,
// a write of the upper dot and a write of the lower dot on the store. The
// front end takes a new beat only after it has handed the previous one to
// the queue; a two-entry command queue lets it run ahead of the back end.
// Reset: the color returns to 1 and a clearing sweep writes every store
// word, TILES_WIDE*TILES_HIGH*16 of them (12288 by default); full stays high
// for that sweep. If the receiver does not pop, the result register holds,
// the back end waits, the queue fills and full rises; nothing is dropped.
module tiled_4bpp_line_plotter_core #(
  parameter int TILES_WIDE = 32,
  parameter int TILES_HIGH = 24,
  parameter int FRAC_BITS  = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        kind_i,
  input  logic signed [tlp_pkg::CoordW-1:0] x_start_i,
  input  logic signed [tlp_pkg::CoordW-1:0] y_start_i,
  input  logic signed [tlp_pkg::CoordW-1:0] x_end_i,
  input  logic signed [tlp_pkg::CoordW-1:0] y_end_i,
  input  logic [tlp_pkg::IndexW-1:0]        read_index_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [tlp_pkg::DataW-1:0]         read_data_o,
  output logic [tlp_pkg::DotsW-1:0]         dots_plotted_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tlp_pkg::ColorW-1:0]        cfg_data_i
);

  localparam int CmdW  = $bits(tlp_pkg::cmd_t);
  localparam int QW    = FRAC_BITS + 1;
  localparam int FifoW = CmdW + 2 * QW;

  logic [tlp_pkg::ColorW-1:0] color_q;
  logic                       accept, front_busy, init_busy;
  logic                       cmd_push, cmd_full, cmd_pop, cmd_empty;
  tlp_pkg::cmd_t              front_cmd, back_cmd;
  logic signed [FRAC_BITS:0]  front_ax, front_ay, back_ax, back_ay;
  logic [FifoW-1:0]           fifo_in, fifo_out;
  tlp_pkg::result_t           res;
  logic                       res_empty;

  // Draw color register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= tlp_pkg::DefaultColor;
    end else if (cfg_valid_i) begin
      color_q <= cfg_data_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  // Input beats are refused while the front end is busy or the store is
  // still being cleared after reset.
  assign full   = front_busy || init_busy;
  assign accept = push && !full;

  tlp_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .kind_i      (kind_i),
    .x_start_i   (x_start_i),
    .y_start_i   (y_start_i),
    .x_end_i     (x_end_i),
    .y_end_i     (y_end_i),
    .read_index_i(read_index_i),
    .cmd_full_i  (cmd_full),
    .busy_o      (front_busy),
    .cmd_push_o  (cmd_push),
    .cmd_o       (front_cmd),
    .ax_o        (front_ax),
    .ay_o        (front_ay)
  );

  // Command plus increments travel through the queue as one word.
  assign fifo_in  = {front_cmd, front_ax, front_ay};
  assign back_cmd = tlp_pkg::cmd_t'(fifo_out[FifoW-1 -: CmdW]);
  assign back_ax  = $signed(fifo_out[2*QW-1 -: QW]);
  assign back_ay  = $signed(fifo_out[QW-1:0]);

  tlp_cmd_fifo #(
    .WIDTH(FifoW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (fifo_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (fifo_out),
    .empty_o(cmd_empty)
  );

  tlp_back #(
    .TILES_WIDE(TILES_WIDE),
    .TILES_HIGH(TILES_HIGH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .cmd_i      (back_cmd),
    .ax_i       (back_ax),
    .ay_i       (back_ay),
    .color_i    (color_q),
    .init_busy_o(init_busy),
    .res_empty_o(res_empty),
    .res_pop_i  (pop && !res_empty),
    .res_o      (res)
  );

  assign empty          = res_empty;
  assign read_data_o    = res.read_data;
  assign dots_plotted_o = res.dots;

endmodule
